// ===== hdl/speex_payload_sample_counter_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Speex payload sample counter - assertion macros
// Shorthand for clocked assertions on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef SPEEX_PAYLOAD_SAMPLE_COUNTER_UNIT_MACROS_SVH
`define SPEEX_PAYLOAD_SAMPLE_COUNTER_UNIT_MACROS_SVH

// same-cycle implication
`define SPSC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("spsc assertion failed");

// next-cycle implication
`define SPSC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("spsc assertion failed");

`endif

// ===== hdl/spsc_pkg.sv =====
// ----------------------------------------------------------------------------
// spsc_pkg
// Sizes, codes, bit-length tables and controller types of the sample counter.
// ----------------------------------------------------------------------------
package spsc_pkg;

  localparam int MAX_BYTES = 256;
  localparam int ADDR_W    = $clog2(MAX_BYTES);
  localparam int BCNT_W    = $clog2(MAX_BYTES + 1);
  // cursor may run past the payload by up to one frame
  localparam int CUR_W     = $clog2(MAX_BYTES * 8) + 2;
  localparam int IDX_W     = CUR_W - 3;
  localparam int FRM_W     = $clog2(MAX_BYTES * 8 / 5 + 1);
  localparam int COUNT_W   = 18;
  localparam int CNT_FULL_W = (FRM_W + 11 > COUNT_W) ? FRM_W + 11 : COUNT_W + 1;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [4:0] CODE_TERM   = 5'd15;
  localparam logic [4:0] CODE_INBAND = 5'd14;
  localparam logic [4:0] CODE_USER   = 5'd13;
  localparam logic [4:0] CODE_NB_MAX = 5'd8;
  localparam logic [1:0] LAYERS_MAX  = 2'd2;

  typedef enum logic [1:0] {
    STOP_EXHAUSTED = 2'd0,
    STOP_TERM      = 2'd1,
    STOP_LAYERS    = 2'd2,
    STOP_UNKNOWN   = 2'd3
  } stop_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_FETCH,
    S_DEC_CODE,
    S_FETCH_EXT,
    S_DEC_EXT,
    S_FINISH
  } state_t;

  typedef enum logic [2:0] {
    K_LAYER,
    K_LAYERS_FULL,
    K_FRAME,
    K_EXT,
    K_TERM,
    K_UNKNOWN
  } kind_t;

  typedef struct packed {
    logic  load;
    logic  clr;
    logic  fetch;
    logic  step_code;
    logic  step_ext;
    logic  set_reason;
    stop_t reason;
    logic  finish;
  } cmd_t;

  typedef struct packed {
    logic  room;
    kind_t kind;
    logic  out_busy;
  } sts_t;

  function automatic logic [8:0] wb_bits(input logic [2:0] mode);
    logic [8:0] r;
    case (mode)
      3'd0:    r = 9'd4;
      3'd1:    r = 9'd36;
      3'd2:    r = 9'd112;
      3'd3:    r = 9'd192;
      3'd4:    r = 9'd352;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [8:0] nb_bits(input logic [3:0] mode);
    logic [8:0] r;
    case (mode)
      4'd0:    r = 9'd5;
      4'd1:    r = 9'd43;
      4'd2:    r = 9'd119;
      4'd3:    r = 9'd160;
      4'd4:    r = 9'd220;
      4'd5:    r = 9'd300;
      4'd6:    r = 9'd364;
      4'd7:    r = 9'd492;
      4'd8:    r = 9'd79;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [6:0] inband_bits(input logic [3:0] id);
    logic [6:0] r;
    case (id)
      4'd0, 4'd1:   r = 7'd1;
      4'd8, 4'd9:   r = 7'd8;
      4'd10, 4'd11: r = 7'd16;
      4'd12, 4'd13: r = 7'd32;
      4'd14, 4'd15: r = 7'd64;
      default:      r = 7'd4;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/spsc_ifs.sv =====
// ----------------------------------------------------------------------------
// spsc interfaces
// Valid/ready channels for payload bytes and for count results.
// ----------------------------------------------------------------------------
interface spsc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       is_last;

  modport source (output valid, output payload_byte, output is_last, input ready);
  modport sink   (input valid, input payload_byte, input is_last, output ready);
endinterface

interface spsc_result_if import spsc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] sample_count;
  logic [1:0]         stop_reason;
  logic               truncated;

  modport source (output valid, output sample_count, output stop_reason,
                  output truncated, input ready);
  modport sink   (input valid, input sample_count, input stop_reason,
                  input truncated, output ready);
endinterface

// ===== hdl/speex_payload_sample_counter_unit.sv =====
// ----------------------------------------------------------------------------
// speex_payload_sample_counter_unit
// Counts decoded samples in a Speex payload loaded one byte per word.
//
//   channel    dir  word                                     handshake
//   payload    in   payload_byte, is_last                    valid/ready
//   result     out  sample_count, stop_reason, truncated     valid/ready
//   cfg        in   rate_shift (cfg_wdata)                   cfg_we, no ready
//
// Bytes load one per cycle; input is held off from the last byte until the
// result is loaded. The walk fetches and decodes each wideband layer, frame
// and signalling block (code, then nibble), ends on no room, a stop or
// unknown code or a third layer, and loads the result once the previous one
// is taken. Bytes of the next payload are taken while a result waits.
// Synchronous reset clears control state; the payload memory is not cleared.
// ----------------------------------------------------------------------------
module speex_payload_sample_counter_unit import spsc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_wdata,
  spsc_byte_if.sink            payload,
  spsc_result_if.source        result
);

  cmd_t cmd;
  sts_t sts;

  spsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (payload.valid),
    .in_last  (payload.is_last),
    .in_ready (payload.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  spsc_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .in_byte      (payload.payload_byte),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .out_ready    (result.ready),
    .out_valid    (result.valid),
    .sample_count (result.sample_count),
    .stop_reason  (result.stop_reason),
    .truncated    (result.truncated)
  );

endmodule

// ===== hdl/spsc_dp.sv =====
// ----------------------------------------------------------------------------
// spsc_dp
// Payload memory, bit cursor, frame counter and the result register.
// ----------------------------------------------------------------------------
module spsc_dp import spsc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic [7:0]         in_byte,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_wdata,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [COUNT_W-1:0] sample_count,
  output logic [1:0]         stop_reason,
  output logic               truncated
);

  logic [7:0]            mem [MAX_BYTES];
  logic [BCNT_W-1:0]     byte_count;
  logic                  overflow;
  logic [CUR_W-1:0]      cursor;
  logic [FRM_W-1:0]      frames;
  logic [1:0]            layers;
  logic                  ext_user;
  stop_t                 reason;
  logic [1:0]            rate_shift;
  logic [7:0]            rd0, rd1;
  logic                  rd0_ok, rd1_ok;

  logic [IDX_W-1:0]      idx0, idx1;
  logic [CUR_W:0]        total, code_end;
  logic [15:0]           window, shifted;
  logic [4:0]            peek;
  logic [3:0]            nib;
  kind_t                 kind;
  logic                  has_room;
  logic [CNT_FULL_W-1:0] base, scaled;
  logic [COUNT_W-1:0]    count_sat;

  assign has_room = byte_count < BCNT_W'(MAX_BYTES);
  assign idx0     = cursor[CUR_W-1:3];
  assign idx1     = idx0 + IDX_W'(1);
  assign total    = (CUR_W+1)'({byte_count, 3'b000});
  assign code_end = {1'b0, cursor} + (CUR_W+1)'(5);

  // two-byte window at the cursor, bytes past the payload read as zero
  assign window  = {rd0_ok ? rd0 : 8'h00, rd1_ok ? rd1 : 8'h00};
  assign shifted = window << cursor[2:0];
  assign peek    = shifted[15:11];
  assign nib     = peek[4:1];

  always_comb begin
    if (peek[4]) begin
      kind = (layers == LAYERS_MAX) ? K_LAYERS_FULL : K_LAYER;
    end else begin
      case (peek)
        CODE_TERM:              kind = K_TERM;
        CODE_INBAND, CODE_USER: kind = K_EXT;
        default:                kind = (peek > CODE_NB_MAX) ? K_UNKNOWN : K_FRAME;
      endcase
    end
  end

  // frames * 160 as two shifts, then the rate shift and saturation
  assign base      = (CNT_FULL_W'(frames) << 7) + (CNT_FULL_W'(frames) << 5);
  assign scaled    = base << rate_shift;
  assign count_sat = (scaled > CNT_FULL_W'(COUNT_MAX)) ? COUNT_MAX
                                                       : scaled[COUNT_W-1:0];

  assign sts.room     = code_end <= total;
  assign sts.kind     = kind;
  assign sts.out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load && has_room) begin
      mem[byte_count[ADDR_W-1:0]] <= in_byte;
    end
    if (cmd.fetch) begin
      rd0    <= mem[idx0[ADDR_W-1:0]];
      rd1    <= mem[idx1[ADDR_W-1:0]];
      rd0_ok <= idx0 < IDX_W'(byte_count);
      rd1_ok <= idx1 < IDX_W'(byte_count);
    end
    if (cmd.set_reason) begin
      reason <= cmd.reason;
    end
    if (cmd.step_code && kind == K_EXT) begin
      ext_user <= (peek == CODE_USER);
    end
    if (cmd.finish) begin
      sample_count <= count_sat;
      stop_reason  <= reason;
      truncated    <= overflow;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      overflow   <= 1'b0;
      cursor     <= '0;
      frames     <= '0;
      layers     <= '0;
      rate_shift <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        rate_shift <= cfg_wdata;
      end

      if (cmd.finish) begin
        byte_count <= '0;
        overflow   <= 1'b0;
      end else if (cmd.load) begin
        if (has_room) begin
          byte_count <= byte_count + BCNT_W'(1);
        end else begin
          overflow <= 1'b1;
        end
      end

      if (cmd.clr) begin
        cursor <= '0;
        frames <= '0;
        layers <= '0;
      end else if (cmd.step_code) begin
        case (kind)
          K_LAYER: begin
            cursor <= cursor + CUR_W'(wb_bits(peek[3:1]));
            layers <= layers + 2'd1;
          end
          K_FRAME: begin
            cursor <= cursor + CUR_W'(nb_bits(peek[3:0]));
            frames <= frames + FRM_W'(1);
            layers <= '0;
          end
          K_EXT: begin
            cursor <= cursor + CUR_W'(5);
          end
          default: begin
            cursor <= cursor;
          end
        endcase
      end else if (cmd.step_ext) begin
        // user data: the nibble and 5 further bits skipped, then nib bytes
        if (ext_user) begin
          cursor <= cursor + CUR_W'(9) + CUR_W'({nib, 3'b000});
        end else begin
          cursor <= cursor + CUR_W'(4) + CUR_W'(inband_bits(nib));
        end
        layers <= '0;
      end

      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/spsc_ctrl.sv =====
// ----------------------------------------------------------------------------
// spsc_ctrl
// Sequencer: byte loading, the bitstream walk and result hand-off.
// ----------------------------------------------------------------------------
module spsc_ctrl import spsc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_last,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last) begin
            cmd.clr    = 1'b1;
            state_next = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        if (!sts.room) begin
          cmd.set_reason = 1'b1;
          cmd.reason     = STOP_EXHAUSTED;
          state_next     = S_FINISH;
        end else begin
          cmd.fetch  = 1'b1;
          state_next = S_DEC_CODE;
        end
      end
      S_DEC_CODE: begin
        case (sts.kind)
          K_LAYER, K_FRAME: begin
            cmd.step_code = 1'b1;
            state_next    = S_FETCH;
          end
          K_EXT: begin
            cmd.step_code = 1'b1;
            state_next    = S_FETCH_EXT;
          end
          K_LAYERS_FULL: begin
            cmd.set_reason = 1'b1;
            cmd.reason     = STOP_LAYERS;
            state_next     = S_FINISH;
          end
          K_TERM: begin
            cmd.set_reason = 1'b1;
            cmd.reason     = STOP_TERM;
            state_next     = S_FINISH;
          end
          K_UNKNOWN: begin
            cmd.set_reason = 1'b1;
            cmd.reason     = STOP_UNKNOWN;
            state_next     = S_FINISH;
          end
          default: begin
            cmd.set_reason = 1'b1;
            cmd.reason     = STOP_UNKNOWN;
            state_next     = S_FINISH;
          end
        endcase
      end
      // signalling length nibble, read without a room check
      S_FETCH_EXT: begin
        cmd.fetch  = 1'b1;
        state_next = S_DEC_EXT;
      end
      S_DEC_EXT: begin
        cmd.step_ext = 1'b1;
        state_next   = S_FETCH;
      end
      S_FINISH: begin
        if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          state_next = S_LOAD;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

endmodule

// ===== hdl/spsc_checker.sv =====
// ----------------------------------------------------------------------------
// spsc_checker
// Port-level checks of the sample counter, bound to the top level.
// ----------------------------------------------------------------------------
`include "speex_payload_sample_counter_unit_macros.svh"

module spsc_checker import spsc_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               in_last,
  input logic               out_valid,
  input logic               out_ready,
  input logic [COUNT_W-1:0] sample_count,
  input logic [1:0]         stop_reason,
  input logic               truncated
);

  // a stalled result keeps its word
  `SPSC_ASSERT_NXT(a_result_hold, out_valid && !out_ready, out_valid && $stable(sample_count) && $stable(stop_reason) && $stable(truncated))

  // the walk starts right after the last byte, so no byte is taken then
  `SPSC_ASSERT_NXT(a_walk_blocks_input, in_valid && in_ready && in_last, !in_ready)

  // a new result is only loaded while the walk holds off input
  `SPSC_ASSERT_IMP(a_result_from_walk, $rose(out_valid), !$past(in_ready))

endmodule

bind speex_payload_sample_counter_unit spsc_checker u_spsc_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (payload.valid),
  .in_ready     (payload.ready),
  .in_last      (payload.is_last),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .sample_count (result.sample_count),
  .stop_reason  (result.stop_reason),
  .truncated    (result.truncated)
);

// ===== dv/tb_speex_payload_sample_counter_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_speex_payload_sample_counter_unit
// Feeds Speex payloads into the sample counter one byte per word. Each payload
// is built bit by bit from frames, wideband layers, signalling blocks,
// terminators and noise. An in-bench model walks every payload as it is taken,
// and each result word is checked against the oldest predicted count. Phases
// vary the rate register and how often the sender idles and the receiver stalls.
// ----------------------------------------------------------------------------
module tb_speex_payload_sample_counter_unit;
  import spsc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned SETTLE      = 16;
  localparam int unsigned RAND_WORDS  = 70;
  localparam int unsigned SAMPLES     = 160;
  localparam int unsigned SAT_COUNT   = 262143;

  // bit lengths per mode, counted from the first bit of the frame or layer
  localparam int unsigned WB_LEN [8]  = '{4, 36, 112, 192, 352, 0, 0, 0};
  localparam int unsigned NB_LEN [16] = '{5, 43, 119, 160, 220, 300, 364, 492,
                                          79, 0, 0, 0, 0, 0, 0, 0};
  localparam int unsigned IB_LEN [16] = '{1, 1, 4, 4, 4, 4, 4, 4,
                                          8, 8, 16, 16, 32, 32, 64, 64};

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_word_t;

  typedef struct packed {
    logic [COUNT_W-1:0] samples;
    stop_t              reason;
    logic               trunc;
  } count_word_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_we;
  logic [1:0] cfg_wdata;

  spsc_byte_if   byte_bus ();
  spsc_result_if res_bus ();

  speex_payload_sample_counter_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .payload   (byte_bus),
    .result    (res_bus)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  byte_word_t  byte_words [$];
  count_word_t exp_counts [$];
  bit          bits_q [$];
  int unsigned words_queued = 0;
  int unsigned words_sent = 0;
  int unsigned errors = 0;
  int unsigned cycle_cnt = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned hold_left;
  logic        hold_req;

  // model state
  logic [7:0]  pl_mem [MAX_BYTES];
  int unsigned pl_len = 0;
  bit          pl_over = 1'b0;
  logic [1:0]  rate_model = 2'd0;

  // ---------------------------------------------------------------- model
  function automatic int unsigned get_bits(int unsigned pos, int unsigned n);
    int unsigned v, p, idx;
    v = 0;
    for (int unsigned i = 0; i < n; i++) begin
      p = pos + i;
      idx = p >> 3;
      v = v << 1;
      if (idx < pl_len && idx < MAX_BYTES) v = v | pl_mem[idx][7 - (p & 7)];
    end
    return v;
  endfunction

  function automatic bit has_room(int unsigned cur, int unsigned total);
    return cur <= total && total - cur >= 5;
  endfunction

  function automatic stop_t walk_payload(output int unsigned frames);
    int unsigned total, cur, layers, c;
    total = pl_len * 8;
    cur = 0;
    frames = 0;
    while (has_room(cur, total)) begin
      layers = 0;
      while (has_room(cur, total) && get_bits(cur, 1) == 1) begin
        if (layers == 2) return STOP_LAYERS;
        c = get_bits(cur + 1, 3);
        cur += WB_LEN[c];
        layers++;
      end
      if (!has_room(cur, total)) return STOP_EXHAUSTED;
      c = get_bits(cur, 5);
      cur += 5;
      if (c == 15) begin
        return STOP_TERM;
      end else if (c == 14) begin
        c = get_bits(cur, 4);
        cur += 4 + IB_LEN[c];
      end else if (c == 13) begin
        c = get_bits(cur, 4);
        cur += 9 + c * 8;
      end else if (c > 8) begin
        return STOP_UNKNOWN;
      end else begin
        cur += NB_LEN[c] - 5;
        frames++;
      end
    end
    return STOP_EXHAUSTED;
  endfunction

  task automatic load_byte(logic [7:0] data, logic last);
    int unsigned frames;
    longint unsigned cnt;
    count_word_t w;
    if (pl_len < MAX_BYTES) begin
      pl_mem[pl_len] = data;
      pl_len++;
    end else begin
      pl_over = 1'b1;
    end
    if (last) begin
      w.reason = walk_payload(frames);
      cnt = longint'(frames * SAMPLES) << rate_model;
      if (cnt > SAT_COUNT) cnt = SAT_COUNT;
      w.samples = cnt[COUNT_W-1:0];
      w.trunc = pl_over;
      exp_counts.push_back(w);
      pl_len = 0;
      pl_over = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------- driver
  always @(posedge clk) begin : drive
    byte_word_t w;
    if (rst) begin
      byte_bus.valid <= 1'b0;
      byte_bus.payload_byte <= 8'h00;
      byte_bus.is_last <= 1'b0;
    end else begin
      if (byte_bus.valid && byte_bus.ready) begin
        load_byte(byte_bus.payload_byte, byte_bus.is_last);
        words_sent++;
      end
      if (!byte_bus.valid || byte_bus.ready) begin
        if (byte_words.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          w = byte_words.pop_front();
          byte_bus.valid <= 1'b1;
          byte_bus.payload_byte <= w.data;
          byte_bus.is_last <= w.last;
        end else begin
          byte_bus.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (errors < 40)
      $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycle_cnt);
    errors++;
  endtask

  always @(posedge clk) begin : watch
    count_word_t want;
    if (rst) begin
      res_bus.ready <= 1'b0;
    end else begin
      if (res_bus.valid && res_bus.ready) begin
        if (exp_counts.size() == 0) begin
          report_mismatch("unexpected word", res_bus.sample_count, 0);
        end else begin
          want = exp_counts.pop_front();
          if (res_bus.sample_count !== want.samples)
            report_mismatch("sample_count", res_bus.sample_count, want.samples);
          if (res_bus.stop_reason !== want.reason)
            report_mismatch("stop_reason", res_bus.stop_reason, want.reason);
          if (res_bus.truncated !== want.trunc)
            report_mismatch("truncated", res_bus.truncated, want.trunc);
        end
      end
      res_bus.ready <= !hold_req && hold_left == 0 && $urandom_range(99) >= rx_stall_pct;
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (rst) hold_left <= 0;
    else if (hold_req) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("tb_speex_payload_sample_counter_unit NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------- payload build
  task automatic push_word(logic [7:0] data, logic last);
    byte_words.push_back('{data: data, last: last});
    words_queued++;
  endtask

  task automatic put_bits(int n, logic [31:0] v);
    for (int i = n - 1; i >= 0; i--) bits_q.push_back(v[i]);
  endtask

  task automatic put_rand(int unsigned n);
    for (int unsigned i = 0; i < n; i++) bits_q.push_back($urandom_range(1));
  endtask

  // pad to a byte boundary with random bits and queue the payload
  task automatic close_payload();
    logic [7:0] b;
    int unsigned nbytes;
    while (bits_q.size() % 8 != 0) bits_q.push_back($urandom_range(1));
    nbytes = bits_q.size() / 8;
    for (int unsigned i = 0; i < nbytes; i++) begin
      for (int j = 7; j >= 0; j--) b[j] = bits_q.pop_front();
      push_word(b, i == nbytes - 1);
    end
  endtask

  task automatic put_frame(int unsigned m);
    put_bits(5, m);
    put_rand(NB_LEN[m] - 5);
  endtask

  task automatic put_layer(int unsigned m);
    put_bits(1, 1);
    put_bits(3, m);
    put_rand(WB_LEN[m] > 4 ? WB_LEN[m] - 4 : 0);
  endtask

  task automatic gen_payload();
    int unsigned n, r, k, m;
    bit stop;
    if ($urandom_range(9) == 0) begin
      // raw noise
      n = $urandom_range(1, 12);
      for (int unsigned i = 0; i < n; i++) push_word($urandom_range(255), i == n - 1);
    end else begin
      n = $urandom_range(1, 4);
      stop = 1'b0;
      for (int unsigned t = 0; t < n && !stop; t++) begin
        r = $urandom_range(99);
        if (r < 10) begin
          k = ($urandom_range(9) == 0) ? 3 : $urandom_range(1, 2);
          for (int unsigned i = 0; i < k; i++) begin
            m = ($urandom_range(7) == 0) ? $urandom_range(5, 7) :
                ($urandom_range(3) == 0) ? $urandom_range(2, 4) : $urandom_range(0, 1);
            put_layer(m);
          end
        end else if (r < 60) begin
          k = $urandom_range(9);
          m = (k < 2) ? 0 : (k < 4) ? 1 : (k < 6) ? 8 : $urandom_range(8);
          put_frame(m);
        end else if (r < 70) begin
          m = $urandom_range(15);
          put_bits(5, CODE_INBAND);
          put_bits(4, m);
          put_rand(IB_LEN[m]);
        end else if (r < 80) begin
          m = $urandom_range(15);
          put_bits(5, CODE_USER);
          put_bits(4, m);
          put_rand(5 + m * 8);
        end else if (r < 86) begin
          put_bits(5, CODE_TERM);
          put_rand($urandom_range(16));
          stop = 1'b1;
        end else if (r < 90) begin
          put_bits(5, $urandom_range(9, 12));
          put_rand($urandom_range(8));
          stop = 1'b1;
        end else begin
          put_rand($urandom_range(1, 16));
        end
      end
      close_payload();
    end
  endtask

  task automatic gen_random_words();
    int unsigned start;
    start = words_queued;
    while (words_queued - start < RAND_WORDS) gen_payload();
  endtask

  // wait until every queued word is taken and every count has come back
  task automatic drain_all();
    do @(posedge clk);
    while (words_sent != words_queued || exp_counts.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_rate(logic [1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    rate_model = v;
  endtask

  // ---------------------------------------------------------------- sequence
  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = 2'd0;
    hold_req = 1'b0;
    byte_bus.valid = 1'b0;
    byte_bus.payload_byte = 8'h00;
    byte_bus.is_last = 1'b0;
    res_bus.ready = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    write_rate(2'd0);

    // directed, no idling
    push_word(8'h00, 1'b1);                 // one mode-0 frame
    push_word(8'hFF, 1'b1);                 // reserved wideband mode, layer seen thrice
    push_word(8'hD0, 1'b1);
    put_bits(5, CODE_TERM); close_payload();
    for (int unsigned c = 9; c <= 12; c++) begin
      put_bits(5, c); close_payload();
    end
    for (int unsigned m = 0; m <= 8; m++) put_frame(m);
    put_bits(5, CODE_TERM); close_payload();
    put_layer(4); put_layer(3); put_frame(1); close_payload();
    put_layer(0); put_layer(1); put_bits(1, 1); put_rand(8); close_payload();
    for (int unsigned id = 0; id < 16; id++) begin
      put_bits(5, CODE_INBAND); put_bits(4, id); put_rand(IB_LEN[id]);
    end
    put_frame(0); close_payload();
    put_bits(5, CODE_USER); put_bits(4, 15); put_rand(125);
    put_bits(5, CODE_USER); put_bits(4, 0); put_rand(5);
    put_frame(2); close_payload();
    // frame running past the end of the payload
    put_bits(5, 7); put_rand(11); close_payload();
    put_layer(2); close_payload();
    push_word(8'h0F, 1'b0); push_word(8'hFF, 1'b1);
    drain_all();

    // full store and overflow at the top shift, count saturates
    write_rate(2'd3);
    push_word(8'h00, 1'b1);
    for (int unsigned i = 0; i < MAX_BYTES + 4; i++)
      push_word(i == MAX_BYTES + 3 ? 8'hFF : 8'h00, i == MAX_BYTES + 3);
    drain_all();
    // full store without overflow, largest count below saturation
    write_rate(2'd2);
    for (int unsigned i = 0; i < MAX_BYTES; i++) push_word(8'h00, i == MAX_BYTES - 1);
    drain_all();

    write_rate(2'd1);
    tx_idle_pct = 83; rx_stall_pct = 0;
    gen_random_words();
    drain_all();

    write_rate(2'd2);
    tx_idle_pct = 0; rx_stall_pct = 83;
    gen_random_words();
    drain_all();

    write_rate(2'd0);
    tx_idle_pct = 32; rx_stall_pct = 32;
    gen_random_words();
    drain_all();

    // receiver holds off while the sender keeps offering words
    write_rate(2'd3);
    tx_idle_pct = 0; rx_stall_pct = 0;
    gen_random_words();
    @(posedge clk);
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    drain_all();

    if (errors == 0 && exp_counts.size() == 0) begin
      $display("tb_speex_payload_sample_counter_unit OK");
    end else begin
      $display("tb_speex_payload_sample_counter_unit NOT OK");
    end
    $finish;
  end

endmodule
